/* rtl/rws_pkg.sv */
`default_nettype none

package rws_pkg;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIVM = 7'b0001000,
        ST_DIVV = 7'b0010000,
        ST_SQRT = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic divm_start;
        logic divv_start;
        logic sqrt_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/rws_in_if.sv */
`default_nettype none

interface rws_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

/* rtl/rws_out_if.sv */
`default_nettype none

interface rws_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int WINDOW_MAX  = 256
);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic                          valid;
    logic                          ready;
    logic signed [SUM_W-1:0]       window_sum;
    logic signed [SAMPLE_BITS-1:0] window_mean;
    logic signed [SAMPLE_BITS-1:0] window_min;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic [SAMPLE_BITS-1:0]        window_stddev;
    logic [CNT_W-1:0]              window_count;

    modport source (
        output valid, output window_sum, output window_mean, output window_min,
        output window_max, output window_stddev, output window_count, input ready
    );
    modport sink (
        input valid, input window_sum, input window_mean, input window_min,
        input window_max, input window_stddev, input window_count, output ready
    );
endinterface

`default_nettype wire

/* rtl/rolling_window_statistics.sv */
`default_nettype none

// Rolling window statistics. Each sample transaction yields one result transaction
// with the sum, mean, min, max, population standard deviation and count over the last
// min(samples since restart, window_length) samples. One sample is in work at a time;
// its transaction runs through the one-entry-per-cycle scan of the sample ring, the
// shift-add multiply, two passes of the bit-serial divider (mean, variance) and the
// bit-pair square root. A finished result waits in an output register while the next
// sample is taken. window_length must be written through cfg_we/cfg_data only while
// idle; the block itself does not enforce this. 0 acts as 1, above WINDOW_MAX as
// WINDOW_MAX.
module rolling_window_statistics #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    rws_in_if.sink                                   samples,
    rws_out_if.source                                stats,
    input  wire logic                                cfg_we,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]     cfg_data
);
    rws_pkg::cmd_t cmd;
    rws_pkg::sts_t sts;

    rws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .out_ready (stats.ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (samples.ready),
        .out_valid (stats.valid)
    );

    rws_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .sample        (samples.sample),
        .restart       (samples.restart),
        .window_sum    (stats.window_sum),
        .window_mean   (stats.window_mean),
        .window_min    (stats.window_min),
        .window_max    (stats.window_max),
        .window_stddev (stats.window_stddev),
        .window_count  (stats.window_count)
    );

endmodule

`default_nettype wire

/* rtl/rws_div.sv */
`default_nettype none

module rws_div #(
    parameter int NUM_W = 50,
    parameter int DV_W  = 18
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DV_W-1:0]  divisor,
    output logic                  busy,
    output logic [NUM_W-1:0]      quotient
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] qd_reg;
    logic [DV_W-1:0]  rem_reg;
    logic [DV_W-1:0]  dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DV_W:0]    rem_sh;
    logic [DV_W:0]    rem_diff;
    logic             ge;

    assign rem_sh   = {rem_reg, qd_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            qd_reg  <= {qd_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DV_W-1:0] : rem_sh[DV_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = qd_reg;

endmodule

`default_nettype wire

/* rtl/rws_dp.sv */
`default_nettype none

module rws_dp #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire rws_pkg::cmd_t                            cmd,
    output rws_pkg::sts_t                                 sts,
    input  wire logic                                     cfg_we,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]          cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]            sample,
    input  wire logic                                     restart,
    output logic signed [SAMPLE_BITS+$clog2(WINDOW_MAX)-1:0] window_sum,
    output logic signed [SAMPLE_BITS-1:0]                 window_mean,
    output logic signed [SAMPLE_BITS-1:0]                 window_min,
    output logic signed [SAMPLE_BITS-1:0]                 window_max,
    output logic [SAMPLE_BITS-1:0]                        window_stddev,
    output logic [$clog2(WINDOW_MAX+1)-1:0]               window_count
);
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SB + AW;
    localparam int SQ_W  = 2 * SB + CNT_W - 1;
    localparam int NUM_W = 2 * SB + 2 * CNT_W;
    localparam int DV_W  = 2 * CNT_W;
    localparam int VAR_W = 2 * SB;
    localparam int MC_W  = $clog2(CNT_W + 1);
    localparam int SC_W  = $clog2(SB + 1);

    // configuration and series state
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [AW-1:0]    slot_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] n_next;
    logic [AW-1:0]    slot_inc;

    // ring scan
    logic signed [SB-1:0] ring_mem [WINDOW_MAX];
    logic [AW-1:0]        rd_addr_reg;
    logic [AW-1:0]        addr_dec;
    logic [CNT_W-1:0]     issue_cnt_reg;
    logic signed [SB-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic signed [SB-1:0] v_reg;
    logic [2*SB-1:0]      sqp_reg;
    logic signed [2*SB-1:0] sq_full;
    logic                 p_vld_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic signed [SB-1:0] min_reg;
    logic signed [SB-1:0] max_reg;

    // n*sumsq - sum^2
    logic [NUM_W-1:0]     mp_reg;
    logic [CNT_W-1:0]     mier_reg;
    logic [MC_W-1:0]      mcnt_reg;
    logic                 mbusy_reg;
    logic [NUM_W-1:0]     ss_reg;
    logic [DV_W-1:0]      nn_reg;
    logic signed [2*SUM_W-1:0] ss_full;
    logic [DV_W-1:0]      nn_full;
    logic [NUM_W-1:0]     sq_ext;
    logic [NUM_W-1:0]     num;

    // divider
    logic                 sum_neg;
    logic [SUM_W-1:0]     abs_sum;
    logic                 div_start;
    logic [NUM_W-1:0]     div_dividend;
    logic [DV_W-1:0]      div_divisor;
    logic                 div_busy;
    logic [NUM_W-1:0]     div_q;
    logic signed [SB-1:0] mean_reg;

    // square root
    logic [VAR_W-1:0]     x_reg;
    logic [SB-1:0]        res_reg;
    logic [SB:0]          rem_reg;
    logic [SC_W-1:0]      scnt_reg;
    logic                 sbusy_reg;
    logic [SB+2:0]        rt_sh;
    logic [SB+2:0]        rt_trial;
    logic [SB+2:0]        rt_diff;
    logic                 rt_ge;

    // output registers
    logic signed [SUM_W-1:0] o_sum_reg;
    logic signed [SB-1:0]    o_mean_reg;
    logic signed [SB-1:0]    o_min_reg;
    logic signed [SB-1:0]    o_max_reg;
    logic [SB-1:0]           o_std_reg;
    logic [CNT_W-1:0]        o_cnt_reg;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (len_reg > CNT_W'(WINDOW_MAX))
        begin
            eff_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign fill_next = restart ? CNT_W'(1) :
                       (fill_reg == CNT_W'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
    assign n_next    = (fill_next < eff_len) ? fill_next : eff_len;
    assign slot_inc  = (slot_reg == AW'(WINDOW_MAX - 1)) ? '0 : slot_reg + 1'b1;
    assign addr_dec  = (rd_addr_reg == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= CNT_W'(1);
            fill_reg      <= '0;
            slot_reg      <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            p_vld_reg     <= 1'b0;
            mbusy_reg     <= 1'b0;
            mcnt_reg      <= '0;
            sbusy_reg     <= 1'b0;
            scnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                fill_reg      <= fill_next;
                slot_reg      <= slot_inc;
                issue_cnt_reg <= n_next;
            end
            else if (issue_cnt_reg != '0)
            begin
                issue_cnt_reg <= issue_cnt_reg - 1'b1;
            end
            rd_vld_reg <= (issue_cnt_reg != '0) && !cmd.load;
            p_vld_reg  <= rd_vld_reg;

            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= MC_W'(CNT_W);
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
                if (mcnt_reg == MC_W'(1))
                begin
                    mbusy_reg <= 1'b0;
                end
            end

            if (cmd.sqrt_start)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= SC_W'(SB);
            end
            else if (sbusy_reg)
            begin
                scnt_reg <= scnt_reg - 1'b1;
                if (scnt_reg == SC_W'(1))
                begin
                    sbusy_reg <= 1'b0;
                end
            end
        end
    end

    // ring: one write on load, one registered read per scan cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring_mem[slot_reg] <= sample;
        end
        rd_data_reg <= ring_mem[rd_addr_reg];
    end

    assign sq_full = rd_data_reg * rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_addr_reg <= slot_reg;
            n_reg       <= n_next;
            sum_reg     <= '0;
            sq_reg      <= '0;
            min_reg     <= {1'b0, {(SB-1){1'b1}}};
            max_reg     <= {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            if (issue_cnt_reg != '0)
            begin
                rd_addr_reg <= addr_dec;
            end
            if (p_vld_reg)
            begin
                sum_reg <= sum_reg + {{AW{v_reg[SB-1]}}, v_reg};
                sq_reg  <= sq_reg + {{(SQ_W-2*SB){1'b0}}, sqp_reg};
                if (v_reg < min_reg)
                begin
                    min_reg <= v_reg;
                end
                if (v_reg > max_reg)
                begin
                    max_reg <= v_reg;
                end
            end
        end
        v_reg   <= rd_data_reg;
        sqp_reg <= sq_full;
    end

    assign ss_full = sum_reg * sum_reg;
    assign nn_full = n_reg * n_reg;
    assign sq_ext  = {{(NUM_W-SQ_W){1'b0}}, sq_reg};
    assign num     = mp_reg - ss_reg;

    // shift-add n * sumsq, MSB of n first
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mp_reg   <= '0;
            mier_reg <= n_reg;
            ss_reg   <= NUM_W'($unsigned(ss_full));
            nn_reg   <= nn_full;
        end
        else if (mbusy_reg)
        begin
            mp_reg   <= {mp_reg[NUM_W-2:0], 1'b0} + (mier_reg[CNT_W-1] ? sq_ext : '0);
            mier_reg <= {mier_reg[CNT_W-2:0], 1'b0};
        end
    end

    assign sum_neg      = sum_reg[SUM_W-1];
    assign abs_sum      = sum_neg ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign div_start    = cmd.divm_start | cmd.divv_start;
    assign div_dividend = cmd.divm_start ? NUM_W'(abs_sum) : num;
    assign div_divisor  = cmd.divm_start ? DV_W'(n_reg) : nn_reg;

    rws_div #(
        .NUM_W (NUM_W),
        .DV_W  (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.divv_start)
        begin
            mean_reg <= sum_neg ? -$signed(div_q[SB-1:0]) : $signed(div_q[SB-1:0]);
        end
    end

    // digit-by-digit square root, two radicand bits per cycle
    assign rt_sh    = {rem_reg, x_reg[VAR_W-1:VAR_W-2]};
    assign rt_trial = {1'b0, res_reg, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;
    assign rt_diff  = rt_sh - rt_trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            x_reg   <= div_q[VAR_W-1:0];
            res_reg <= '0;
            rem_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            x_reg   <= {x_reg[VAR_W-3:0], 2'b00};
            res_reg <= {res_reg[SB-2:0], rt_ge};
            rem_reg <= rt_ge ? rt_diff[SB:0] : rt_sh[SB:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_sum_reg  <= sum_reg;
            o_mean_reg <= mean_reg;
            o_min_reg  <= min_reg;
            o_max_reg  <= max_reg;
            o_std_reg  <= res_reg;
            o_cnt_reg  <= n_reg;
        end
    end

    assign sts.scan_done = (issue_cnt_reg == '0) && !rd_vld_reg && !p_vld_reg;
    assign sts.mul_done  = !mbusy_reg;
    assign sts.div_done  = !div_busy;
    assign sts.sqrt_done = !sbusy_reg;

    assign window_sum    = o_sum_reg;
    assign window_mean   = o_mean_reg;
    assign window_min    = o_min_reg;
    assign window_max    = o_max_reg;
    assign window_stddev = o_std_reg;
    assign window_count  = o_cnt_reg;

endmodule

`default_nettype wire

/* rtl/rws_ctrl.sv */
`default_nettype none

module rws_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          out_ready,
    input  wire rws_pkg::sts_t sts,
    output rws_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid
);
    rws_pkg::state_t state_reg;
    rws_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rws_pkg::ST_SCAN;
                end
            end
            rws_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = rws_pkg::ST_MUL;
                end
            end
            rws_pkg::ST_MUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.divm_start = 1'b1;
                    state_next     = rws_pkg::ST_DIVM;
                end
            end
            rws_pkg::ST_DIVM:
            begin
                if (sts.div_done)
                begin
                    cmd.divv_start = 1'b1;
                    state_next     = rws_pkg::ST_DIVV;
                end
            end
            rws_pkg::ST_DIVV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = rws_pkg::ST_SQRT;
                end
            end
            rws_pkg::ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    state_next = rws_pkg::ST_DONE;
                end
            end
            rws_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rws_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == rws_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/rws_checker.sv */
`default_nettype none

module rws_checker #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic signed [SAMPLE_BITS-1:0]    out_mean,
    input wire logic signed [SAMPLE_BITS-1:0]    out_min,
    input wire logic signed [SAMPLE_BITS-1:0]    out_max,
    input wire logic [$clog2(WINDOW_MAX+1)-1:0]  out_count
);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while previous one still in work");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_min <= out_max)
        else $error("window min above max");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_mean >= out_min && out_mean <= out_max)
        else $error("mean outside min/max");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count != '0 && out_count <= CNT_W'(WINDOW_MAX))
        else $error("window count out of range");

endmodule

bind rolling_window_statistics rws_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .out_mean  (stats.window_mean),
    .out_min   (stats.window_min),
    .out_max   (stats.window_max),
    .out_count (stats.window_count)
);

`default_nettype wire
